### rtl/ihp_pkg.sv
`timescale 1ns / 1ps

package ihp_pkg;

    // IGMP message types
    localparam logic [7:0] T_QUERY     = 8'h11;
    localparam logic [7:0] T_REPORT_V1 = 8'h12;
    localparam logic [7:0] T_REPORT_V2 = 8'h16;
    localparam logic [7:0] T_LEAVE_V2  = 8'h17;
    localparam logic [7:0] T_REPORT_V3 = 8'h22;

    localparam logic [31:0] RGMP_ADDR_RESET = 32'hE000_0019;

    // (65535 - 24 - 12) / 4
    localparam int unsigned MAX_QUERY_SOURCES = (65535 - 24 - 12) / 4;

    localparam logic [15:0] BASE_HDR     = 16'd8;
    localparam logic [15:0] QUERY_V3_HDR = 16'd12;

    localparam logic [7:0] VER_1       = 8'd1;
    localparam logic [7:0] VER_2       = 8'd2;
    localparam logic [7:0] VER_3       = 8'd3;
    localparam logic [7:0] VER_UNKNOWN = 8'd255;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_TOO_SMALL    = 2'd1,
        ST_V3_TOO_SMALL = 2'd2,
        ST_MALFORMED    = 2'd3
    } status_t;

    // Per-message parse context
    typedef struct packed {
        logic        msg_active;
        logic        parse_done;
        logic [15:0] byte_offset;
        logic [7:0]  message_type;
        logic [7:0]  resp_time;
        logic [15:0] count_field;
        logic [15:0] records_left;
        logic [16:0] next_record_offset;
        logic [7:0]  record_aux_words;
        logic [15:0] record_sources;
        logic [16:0] running_header_length;
        status_t     error_code;
        logic [7:0]  result_version;
        logic [15:0] pkt_len;
        logic        pkt_rgmp;
    } ihp_state_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  igmp_version;
        logic [15:0] header_length;
        logic [15:0] payload_length;
        logic        is_rgmp;
    } ihp_result_t;

endpackage

### rtl/ihp_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one message byte.
module ihp_step import ihp_pkg::*; (
    input  ihp_state_t  cur_state,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [15:0] packet_length,
    input  logic        is_ipv4,
    input  logic [31:0] dest_address,
    input  logic [7:0]  ip_ttl,
    input  logic [31:0] rgmp_addr,
    output ihp_state_t  nxt_state,
    output logic        res_valid,
    output ihp_result_t res
);

    always_comb begin
        ihp_state_t  s;
        logic [15:0] o;
        logic [15:0] cnt;
        logic [17:0] hl;
        logic [17:0] len18;
        logic [17:0] nro18;
        logic [17:0] base1;
        logic [17:0] base2;
        logic [18:0] base3;
        logic [17:0] aux4;
        logic [17:0] src4;
        logic        boundary;

        s         = cur_state;
        res_valid = 1'b0;
        res       = '0;
        cnt       = '0;
        hl        = '0;
        base1     = '0;
        base2     = '0;
        base3     = '0;
        aux4      = '0;
        src4      = '0;
        boundary  = 1'b0;

        // Start of message: drop any open message and sample the context.
        if (first_byte) begin
            s            = '0;
            s.msg_active = 1'b1;
            s.pkt_len    = packet_length;
            s.pkt_rgmp   = is_ipv4 && (packet_length == BASE_HDR) &&
                           (dest_address == rgmp_addr) && (ip_ttl == 8'd1);
            if (packet_length < BASE_HDR)
                s.error_code = ST_TOO_SMALL;
        end

        o     = s.byte_offset;
        len18 = {2'b00, s.pkt_len};
        nro18 = {1'b0, s.next_record_offset};

        if (s.msg_active) begin
            if (s.error_code == ST_OK && !s.parse_done && o < s.pkt_len) begin
                if (o == 16'd0) begin
                    s.message_type = data_byte;
                    if (data_byte != T_QUERY && data_byte != T_REPORT_V3) begin
                        if (data_byte == T_REPORT_V1)
                            s.result_version = VER_1;
                        else if (data_byte == T_REPORT_V2 || data_byte == T_LEAVE_V2)
                            s.result_version = VER_2;
                        else
                            s.result_version = VER_UNKNOWN;
                        s.running_header_length = {1'b0, BASE_HDR};
                        s.parse_done            = 1'b1;
                    end
                end else begin
                    if (o == 16'd1)
                        s.resp_time = data_byte;
                    if (s.message_type == T_QUERY) begin
                        if (s.pkt_len < QUERY_V3_HDR) begin
                            if (o == 16'd1) begin
                                s.result_version = (data_byte == 8'd0) ? VER_1 : VER_2;
                                s.running_header_length = {1'b0, BASE_HDR};
                                s.parse_done            = 1'b1;
                            end
                        end else if (o == 16'd10) begin
                            s.count_field = {data_byte, 8'h00};
                        end else if (o == 16'd11) begin
                            cnt           = {s.count_field[15:8], data_byte};
                            s.count_field = cnt;
                            hl            = {2'b00, QUERY_V3_HDR} + {cnt, 2'b00};
                            if (32'(cnt) > MAX_QUERY_SOURCES)
                                s.error_code = ST_MALFORMED;
                            else if (len18 < hl)
                                s.error_code = ST_V3_TOO_SMALL;
                            else if (hl >= 18'd65535)
                                s.error_code = ST_MALFORMED;
                            else begin
                                s.result_version        = VER_3;
                                s.running_header_length = hl[16:0];
                                s.parse_done            = 1'b1;
                            end
                        end
                    end else begin
                        // v3 report: record count, then group records
                        if (o == 16'd6) begin
                            s.count_field = {data_byte, 8'h00};
                        end else if (o == 16'd7) begin
                            cnt                     = {s.count_field[15:8], data_byte};
                            s.count_field           = cnt;
                            s.records_left          = cnt;
                            s.next_record_offset    = {1'b0, BASE_HDR};
                            s.running_header_length = {1'b0, BASE_HDR};
                            boundary                = 1'b1;
                        end else if (o >= 16'd8 && {2'b00, o} >= nro18) begin
                            if ({2'b00, o} == nro18 + 18'd1) begin
                                s.record_aux_words = data_byte;
                            end else if ({2'b00, o} == nro18 + 18'd2) begin
                                s.record_sources = {data_byte, 8'h00};
                            end else if ({2'b00, o} == nro18 + 18'd3) begin
                                s.record_sources = {s.record_sources[15:8], data_byte};
                                aux4  = {8'h00, s.record_aux_words, 2'b00};
                                src4  = {s.record_sources, 2'b00};
                                base1 = nro18 + 18'd8;
                                base2 = base1 + aux4;
                                base3 = {1'b0, base2} + {1'b0, src4};
                                if (len18 >= base1 && (len18 - base1) < aux4)
                                    s.error_code = ST_MALFORMED;
                                else if (len18 >= base2 && (len18 - base2) < src4)
                                    s.error_code = ST_MALFORMED;
                                else begin
                                    s.running_header_length = base3[16:0];
                                    s.next_record_offset    = base3[16:0];
                                    s.records_left          = s.records_left - 16'd1;
                                    boundary                = 1'b1;
                                end
                            end
                        end
                    end
                end

                // End of a group record, or record count just known
                if (boundary) begin
                    if (s.records_left == 16'd0) begin
                        if (s.running_header_length >= 17'd65535)
                            s.error_code = ST_MALFORMED;
                        else begin
                            s.result_version = VER_3;
                            s.parse_done     = 1'b1;
                        end
                    end else if (s.pkt_len >= s.next_record_offset[15:0] &&
                                 s.next_record_offset[16] == 1'b0 &&
                                 (s.pkt_len - s.next_record_offset[15:0]) < BASE_HDR) begin
                        s.error_code = ST_V3_TOO_SMALL;
                    end
                end
            end

            if (s.byte_offset != 16'hFFFF)
                s.byte_offset = s.byte_offset + 16'd1;

            if (last_byte) begin
                s.msg_active = 1'b0;
                if (s.error_code == ST_OK && !s.parse_done)
                    s.error_code = ST_TOO_SMALL;
                res_valid  = 1'b1;
                res.status = s.error_code;
                if (s.error_code == ST_OK) begin
                    res.igmp_version   = s.result_version;
                    res.header_length  = s.running_header_length[15:0];
                    res.payload_length = s.pkt_len - s.running_header_length[15:0];
                    res.is_rgmp        = s.pkt_rgmp;
                end
            end
        end

        nxt_state = s;
    end

endmodule

### rtl/igmp_header_parser.sv
`timescale 1ns / 1ps
// A message's result reaches m_* when its last byte moves on from the input register.
// The byte waits in the input register while the parse logic forms the next
// value of the result register.
// Throughput: one byte per cycle while m_ready stays high. A result left waiting on m_*
// holds every beat behind it: the input register takes one more beat, then s_ready drops.
// Reset (aresetn low, synchronous): no message open, both registers empty,
// rgmp_group_address back to 224.0.0.25.
module igmp_header_parser import ihp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: RGMP destination address
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_rgmp_group_address,

    // Message bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    input  logic [15:0] s_packet_length,
    input  logic        s_is_ipv4,
    input  logic [31:0] s_dest_address,
    input  logic [7:0]  s_ip_ttl,

    // Parse results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_igmp_version,
    output logic [15:0] m_header_length,
    output logic [15:0] m_payload_length,
    output logic        m_is_rgmp
);

    logic [31:0] rgmp_addr_reg;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_first_reg;
    logic        in_last_reg;
    logic [15:0] in_len_reg;
    logic        in_ipv4_reg;
    logic [31:0] in_dest_reg;
    logic [7:0]  in_ttl_reg;

    // Parse context and result register
    ihp_state_t  state_reg;
    ihp_state_t  state_next;
    logic        res_valid;
    ihp_result_t res_next;
    logic        m_valid_reg;
    ihp_result_t res_reg;

    logic        advance;

    // Always taken; the user must write it only while the block is idle (not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rgmp_addr_reg <= RGMP_ADDR_RESET;
        end else if (cfg_valid) begin
            rgmp_addr_reg <= cfg_rgmp_group_address;
        end
    end

    // Advance the held beat whenever the result register is free or being drained.
    // Every beat waits on this, also the beats that close no message.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Capture payload on every accepted beat; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
            in_last_reg  <= s_last_byte;
            in_len_reg   <= s_packet_length;
            in_ipv4_reg  <= s_is_ipv4;
            in_dest_reg  <= s_dest_address;
            in_ttl_reg   <= s_ip_ttl;
        end
    end

    ihp_step u_step (
        .cur_state     (state_reg),
        .data_byte     (in_data_reg),
        .first_byte    (in_first_reg),
        .last_byte     (in_last_reg),
        .packet_length (in_len_reg),
        .is_ipv4       (in_ipv4_reg),
        .dest_address  (in_dest_reg),
        .ip_ttl        (in_ttl_reg),
        .rgmp_addr     (rgmp_addr_reg),
        .nxt_state     (state_next),
        .res_valid     (res_valid),
        .res           (res_next)
    );

    // Commit parse context on each advanced beat; load the result register when it closes a message.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            if (advance) begin
                state_reg <= state_next;
                if (res_valid)
                    m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid)
            res_reg <= res_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = res_reg.status;
    assign m_igmp_version   = res_reg.igmp_version;
    assign m_header_length  = res_reg.header_length;
    assign m_payload_length = res_reg.payload_length;
    assign m_is_rgmp        = res_reg.is_rgmp;

`ifndef ASSERT_OFF
    // A finished parse never carries an error as well.
    a_done_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.parse_done && state_reg.error_code != ST_OK))
        else $error("parse finished with an error code set");

    // Any error result zeroes the remaining result fields.
    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |->
            (m_igmp_version == 8'd0 && m_header_length == 16'd0 &&
             m_payload_length == 16'd0 && !m_is_rgmp))
        else $error("error result with nonzero fields");

    // The last beat of an open message always lands in the result register.
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg && (in_first_reg || state_reg.msg_active)) |=> m_valid)
        else $error("last byte of a message produced no result");
`endif

endmodule

### tb/igmp_header_parser_tb.sv
`timescale 1ns / 1ps

module igmp_header_parser_tb;
    import ihp_pkg::*;

    typedef bit [7:0] byte_q [$];

    // IP-side context of a message; the block samples it on the first beat only
    typedef struct packed {
        bit [15:0] len;
        bit        ipv4;
        bit [31:0] dst;
        bit [7:0]  ttl;
    } ip_meta_t;

    // Tracks the message in flight byte by byte and keeps the verdicts that the
    // block owes, oldest first.
    class igmp_msg_model;
        bit [31:0]   rgmp_addr;
        bit          in_msg;
        bit          parsed;
        bit [15:0]   offset;
        bit [7:0]    msg_type;
        bit [7:0]    resp_time;
        int unsigned count;
        int unsigned recs_left;
        int unsigned rec_start;
        int unsigned aux_words;
        int unsigned rec_srcs;
        int unsigned hdr_len;
        int unsigned msg_len;
        status_t     err;
        bit [7:0]    version;
        bit          rgmp;
        ihp_result_t pending_verdicts[$];
        int          bad_fields;

        function new();
            rgmp_addr  = RGMP_ADDR_RESET;
            in_msg     = 1'b0;
            bad_fields = 0;
        endfunction

        function void close_parse(bit [7:0] ver, int unsigned hl);
            version = ver;
            hdr_len = hl;
            parsed  = 1'b1;
        endfunction

        // After a group record, or once the record count is known
        function void record_edge();
            if (recs_left == 0) begin
                if (hdr_len >= 65535)
                    err = ST_MALFORMED;
                else
                    close_parse(VER_3, hdr_len);
            end else if (msg_len - rec_start < 32'd8) begin
                err = ST_V3_TOO_SMALL;
            end
        endfunction

        function void parse(int unsigned o, bit [7:0] b);
            int unsigned hl;
            int unsigned base;
            int unsigned rel;
            bit [7:0]    ver;
            if (o == 0) begin
                msg_type = b;
                if (b != T_QUERY && b != T_REPORT_V3) begin
                    ver = VER_UNKNOWN;
                    if (b == T_REPORT_V1)
                        ver = VER_1;
                    else if (b == T_REPORT_V2 || b == T_LEAVE_V2)
                        ver = VER_2;
                    close_parse(ver, 32'(BASE_HDR));
                end
                return;
            end
            if (o == 1)
                resp_time = b;
            if (msg_type == T_QUERY) begin
                if (msg_len < QUERY_V3_HDR) begin
                    if (o == 1)
                        close_parse(resp_time == 0 ? VER_1 : VER_2, 32'(BASE_HDR));
                end else if (o == 10) begin
                    count = 32'({b, 8'h00});
                end else if (o == 11) begin
                    count |= b;
                    if (count > MAX_QUERY_SOURCES) begin
                        err = ST_MALFORMED;
                        return;
                    end
                    hl = QUERY_V3_HDR + 4 * count;
                    if (msg_len < hl)
                        err = ST_V3_TOO_SMALL;
                    else if (hl >= 65535)
                        err = ST_MALFORMED;
                    else
                        close_parse(VER_3, hl);
                end
                return;
            end
            // v3 report: walk the group records
            if (o == 6) begin
                count = 32'({b, 8'h00});
            end else if (o == 7) begin
                count |= b;
                recs_left = count;
                rec_start = 8;
                hdr_len   = 8;
                record_edge();
            end else if (o >= 8 && o >= rec_start) begin
                rel = o - rec_start;
                if (rel == 1) begin
                    aux_words = b;
                end else if (rel == 2) begin
                    rec_srcs = 32'({b, 8'h00});
                end else if (rel == 3) begin
                    rec_srcs |= b;
                    base = rec_start + 8;
                    if (msg_len - base < aux_words * 4) begin
                        err = ST_MALFORMED;
                        return;
                    end
                    base += aux_words * 4;
                    if (msg_len - base < rec_srcs * 4) begin
                        err = ST_MALFORMED;
                        return;
                    end
                    base += rec_srcs * 4;
                    hdr_len   = base;
                    rec_start = base;
                    recs_left = (recs_left - 1) & 32'hFFFF;
                    record_edge();
                end
            end
        endfunction

        // Note one accepted input beat
        function void take_byte(bit [7:0] b, bit first, bit last, bit [15:0] plen,
                                bit ipv4, bit [31:0] dst, bit [7:0] ttl);
            ihp_result_t r;
            if (first) begin
                in_msg    = 1'b1;
                parsed    = 1'b0;
                offset    = 16'd0;
                msg_type  = 8'd0;
                resp_time = 8'd0;
                count     = 0;
                recs_left = 0;
                rec_start = 0;
                aux_words = 0;
                rec_srcs  = 0;
                hdr_len   = 0;
                version   = 8'd0;
                err       = ST_OK;
                msg_len   = 32'(plen);
                rgmp      = ipv4 && plen == 16'd8 && dst == rgmp_addr && ttl == 8'd1;
                if (plen < BASE_HDR)
                    err = ST_TOO_SMALL;
            end
            if (!in_msg)
                return;
            if (err == ST_OK && !parsed && offset < msg_len)
                parse(offset, b);
            if (offset != 16'hFFFF)
                offset++;
            if (!last)
                return;
            in_msg = 1'b0;
            if (err == ST_OK && !parsed)
                err = ST_TOO_SMALL;
            r = '0;
            r.status = err;
            if (err == ST_OK) begin
                r.igmp_version   = version;
                r.header_length  = 16'(hdr_len);
                r.payload_length = 16'(msg_len - hdr_len);
                r.is_rgmp        = rgmp;
            end
            pending_verdicts.push_back(r);
        endfunction

        function void flag(string field, int want, int got);
            $error("%s: expected %0d, got %0d", field, want, got);
            bad_fields++;
        endfunction

        // Check one accepted result beat against the oldest verdict
        function void match_verdict(logic [1:0] st, logic [7:0] ver, logic [15:0] hl,
                                    logic [15:0] pl, logic rg);
            ihp_result_t want;
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no message pending (status %0d)", st);
                bad_fields++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (want.status !== st)
                flag("status", want.status, st);
            if (want.igmp_version !== ver)
                flag("igmp_version", want.igmp_version, ver);
            if (want.header_length !== hl)
                flag("header_length", want.header_length, hl);
            if (want.payload_length !== pl)
                flag("payload_length", want.payload_length, pl);
            if (want.is_rgmp !== rg)
                flag("is_rgmp", want.is_rgmp, rg);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_rgmp_group_address;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_first_byte;
    logic        s_last_byte;
    logic [15:0] s_packet_length;
    logic        s_is_ipv4;
    logic [31:0] s_dest_address;
    logic [7:0]  s_ip_ttl;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [7:0]  m_igmp_version;
    logic [15:0] m_header_length;
    logic [15:0] m_payload_length;
    logic        m_is_rgmp;

    igmp_msg_model model;
    int            src_idle_pct  = 0;
    int            sink_idle_pct = 0;
    int            msg_beats     = 0;
    bit            pressure_armed;
    bit            hold_done;

    igmp_header_parser dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_rgmp_group_address (cfg_rgmp_group_address),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_data_byte            (s_data_byte),
        .s_first_byte           (s_first_byte),
        .s_last_byte            (s_last_byte),
        .s_packet_length        (s_packet_length),
        .s_is_ipv4              (s_is_ipv4),
        .s_dest_address         (s_dest_address),
        .s_ip_ttl               (s_ip_ttl),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_status               (m_status),
        .m_igmp_version         (m_igmp_version),
        .m_header_length        (m_header_length),
        .m_payload_length       (m_payload_length),
        .m_is_rgmp              (m_is_rgmp)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #400_000;
        $display("FAILURE");
        $finish;
    end

    // Watch both channels at the edge; note input beats before checking results
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready)
                model.take_byte(s_data_byte, s_first_byte, s_last_byte, s_packet_length,
                                s_is_ipv4, s_dest_address, s_ip_ttl);
            if (m_valid && m_ready)
                model.match_verdict(m_status, m_igmp_version, m_header_length,
                                    m_payload_length, m_is_rgmp);
        end
    end

    // Result side: random back-pressure, plus one long hold-off when armed so the
    // block backs up and stalls its input.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (pressure_armed && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic ip_meta_t mk_meta(bit [15:0] len, bit ipv4, bit [31:0] dst,
                                         bit [7:0] ttl);
        ip_meta_t m;
        m.len  = len;
        m.ipv4 = ipv4;
        m.dst  = dst;
        m.ttl  = ttl;
        return m;
    endfunction

    // Random IP context; bias toward the RGMP address and TTL 1, or force both
    function automatic ip_meta_t random_meta(bit [15:0] len, bit rgmp_like);
        ip_meta_t m;
        m.len  = len;
        m.ipv4 = rgmp_like ? 1'b1 : 1'($urandom_range(1));
        m.dst  = (rgmp_like || $urandom_range(3) == 0) ? model.rgmp_addr : $urandom;
        m.ttl  = (rgmp_like || $urandom_range(3) == 0) ? 8'd1 : 8'($urandom_range(255));
        return m;
    endfunction

    // Append random bytes, keeping messages short enough to stay cheap
    function automatic void add_noise(ref byte_q q, input int n);
        while (n > 0 && q.size() < 96) begin
            q.push_back(8'($urandom));
            n--;
        end
    endfunction

    // Offer one beat; hold it until it is taken
    task automatic push_beat(input bit [7:0] b, input bit first, input bit last,
                             input ip_meta_t m);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_first_byte    <= first;
        s_last_byte     <= last;
        s_packet_length <= m.len;
        s_is_ipv4       <= m.ipv4;
        s_dest_address  <= m.dst;
        s_ip_ttl        <= m.ttl;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Send a message; later beats carry junk context, which the block must ignore.
    // Leave it open (no last) when close is low.
    task automatic send_msg(input byte_q bytes, input ip_meta_t m, input bit close);
        for (int i = 0; i < bytes.size(); i++)
            push_beat(bytes[i], i == 0, close && i == bytes.size() - 1,
                      i == 0 ? m : random_meta(16'($urandom), 1'b0));
        msg_beats += bytes.size();
    endtask

    task automatic write_rgmp(input bit [31:0] addr);
        cfg_valid              <= 1'b1;
        cfg_rgmp_group_address <= addr;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        model.rgmp_addr = addr;
    endtask

    // Wait out every owed result, then the pipeline depth and some margin
    task automatic drain();
        s_valid <= 1'b0;
        for (int i = 0; i < 5000 && model.pending_verdicts.size() != 0; i++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_message();
        byte_q    bytes;
        byte_q    part;
        ip_meta_t m;
        int       kind;
        int       len;
        int       cnt;
        int       n_decl;
        int       n_built;
        int       aux;
        int       srcs;
        int       total;
        int       keep;
        bit       rg;
        kind = $urandom_range(99);
        rg   = 1'b0;
        // stray beats outside any message
        if ($urandom_range(19) == 0)
            repeat ($urandom_range(1, 2))
                push_beat(8'($urandom), 1'b0, 1'($urandom_range(1)),
                          random_meta(16'($urandom), 1'b0));
        // open a message and drop it by restarting
        if ($urandom_range(19) == 0) begin
            part.push_back($urandom_range(1) ? T_REPORT_V3 : T_QUERY);
            add_noise(part, $urandom_range(4));
            send_msg(part, random_meta(16'($urandom), 1'b0), 1'b0);
        end
        if (kind < 15) begin
            // fixed 8-byte header types
            case ($urandom_range(3))
                0: bytes.push_back(T_REPORT_V1);
                1: bytes.push_back(T_REPORT_V2);
                2: bytes.push_back(T_LEAVE_V2);
                default: bytes.push_back(8'($urandom));
            endcase
            len = ($urandom_range(4) == 0) ? $urandom_range(65535) : 8;
            add_noise(bytes, $urandom_range(7));
            rg = 1'($urandom_range(1));
        end else if (kind < 30) begin
            // short query: v1 or v2 by max response time
            len = $urandom_range(8, 11);
            bytes.push_back(T_QUERY);
            bytes.push_back($urandom_range(1) ? 8'h00 : 8'($urandom));
            add_noise(bytes, len - 2);
        end else if (kind < 50) begin
            // v3 query, source count near and past the bound now and then
            case ($urandom_range(9))
                7: cnt = MAX_QUERY_SOURCES;
                8: cnt = $urandom_range(65535, MAX_QUERY_SOURCES + 1);
                9: cnt = $urandom_range(65535);
                default: cnt = $urandom_range(5);
            endcase
            len = 12 + 4 * cnt;
            if ($urandom_range(4) == 0)
                len = len - $urandom_range(1, 4);
            else
                len = len + $urandom_range(6);
            if (len > 65535 || $urandom_range(7) == 0)
                len = $urandom_range(65535);
            bytes.push_back(T_QUERY);
            add_noise(bytes, 9);
            bytes.push_back(8'(cnt >> 8));
            bytes.push_back(8'(cnt));
            add_noise(bytes, 4 * (cnt < 6 ? cnt : 2) + $urandom_range(3));
        end else if (kind < 80) begin
            // v3 report with a few small group records
            n_built = $urandom_range(3);
            n_decl  = n_built;
            case ($urandom_range(9))
                0: n_decl = $urandom_range(65535);
                1: if (n_built != 0) n_built--;
                default: ;
            endcase
            bytes.push_back(T_REPORT_V3);
            add_noise(bytes, 5);
            bytes.push_back(8'(n_decl >> 8));
            bytes.push_back(8'(n_decl));
            total = 8;
            repeat (n_built) begin
                aux  = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(2);
                srcs = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(3);
                bytes.push_back(8'($urandom));
                bytes.push_back(8'(aux));
                bytes.push_back(8'(srcs >> 8));
                bytes.push_back(8'(srcs));
                add_noise(bytes, 4 + 4 * (aux + srcs));
                total += 8 + 4 * (aux + srcs);
            end
            len = total;
            case ($urandom_range(9))
                0: len = total - $urandom_range(1, 8);
                1: len = $urandom_range(65535);
                2, 3: len = total + $urandom_range(1, 12);
                default: ;
            endcase
            if (len > 65535)
                len = 65535;
        end else begin
            // noise: junk body under any type and length
            case ($urandom_range(2))
                0: bytes.push_back(T_QUERY);
                1: bytes.push_back(T_REPORT_V3);
                default: bytes.push_back(8'($urandom));
            endcase
            len = $urandom_range(1) ? $urandom_range(40) : $urandom_range(65535);
            add_noise(bytes, $urandom_range(1, 29));
        end
        // run past the length, or cut the message short
        if ($urandom_range(9) == 0)
            add_noise(bytes, $urandom_range(1, 4));
        if ($urandom_range(9) == 0) begin
            keep = $urandom_range(1, bytes.size());
            while (bytes.size() > keep)
                bytes.delete(bytes.size() - 1);
        end
        m = random_meta(16'(len), rg);
        send_msg(bytes, m, 1'b1);
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input bit [31:0] addr,
                             input bit squeeze);
        write_rgmp(addr);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        if (squeeze)
            pressure_armed = 1'b1;
        msg_beats = 0;
        while (msg_beats < 367)
            random_message();
        drain();
    endtask

    initial begin
        byte_q q;
        model = new();
        aresetn                <= 1'b0;
        cfg_valid              <= 1'b0;
        cfg_rgmp_group_address <= 32'd0;
        s_valid                <= 1'b0;
        s_data_byte            <= 8'd0;
        s_first_byte           <= 1'b0;
        s_last_byte            <= 1'b0;
        s_packet_length        <= 16'd0;
        s_is_ipv4              <= 1'b0;
        s_dest_address         <= 32'd0;
        s_ip_ttl               <= 8'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed cases, RGMP address still at its reset value.
        // Length below the base header: too small at once.
        q = {8'hFF};
        send_msg(q, mk_meta(16'd7, 1'b0, 32'h0000_0000, 8'd0), 1'b1);
        // Stray beat with last set and no message open: no result.
        push_beat(8'h00, 1'b0, 1'b1, mk_meta(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF));
        // One-beat v1 report that qualifies as RGMP.
        q = {T_REPORT_V1};
        send_msg(q, mk_meta(16'd8, 1'b1, RGMP_ADDR_RESET, 8'd1), 1'b1);
        // v2 report at the largest length: payload is the rest.
        q = {T_REPORT_V2};
        send_msg(q, mk_meta(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF), 1'b1);
        // Leave to the RGMP address with TTL 2: not RGMP.
        q = {T_LEAVE_V2};
        send_msg(q, mk_meta(16'd8, 1'b1, RGMP_ADDR_RESET, 8'd2), 1'b1);
        // Unknown type.
        q = {8'h00};
        send_msg(q, mk_meta(16'd8, 1'b0, 32'h0000_0000, 8'd1), 1'b1);
        // Open a query, then restart with a v1 query (zero response time).
        q = {T_QUERY};
        send_msg(q, mk_meta(16'd12, 1'b1, RGMP_ADDR_RESET, 8'd1), 1'b0);
        q = {T_QUERY, 8'h00};
        send_msg(q, mk_meta(16'd8, 1'b1, RGMP_ADDR_RESET, 8'd1), 1'b1);
        // v2 query: short length, nonzero response time.
        q = {T_QUERY, 8'hFF};
        send_msg(q, mk_meta(16'd11, 1'b0, 32'h0000_0000, 8'd0), 1'b1);
        // v3-sized query cut off before its source count arrives.
        q = {T_QUERY, 8'h64};
        send_msg(q, mk_meta(16'd12, 1'b1, 32'h0A00_0001, 8'd64), 1'b1);
        // v3 query right at the source bound, largest length.
        q = {T_QUERY, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
             8'h3F, 8'hF6};
        send_msg(q, mk_meta(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF), 1'b1);
        drain();

        // Random traffic under three back-pressure profiles and three addresses
        run_phase(15, 74, 32'h0000_0000, 1'b0);
        run_phase(74, 15, 32'hFFFF_FFFF, 1'b0);
        run_phase(0, 0, $urandom, 1'b1);

        if (model.pending_verdicts.size() != 0)
            $error("%0d results never came", model.pending_verdicts.size());
        if (model.bad_fields == 0 && model.pending_verdicts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
